// File: rtl/pdad_pkg.sv
// Package of the PWM duty-cycle angle decoder.
// Holds field widths, event codes, constants and the command and status structs between controller and datapath.
// No dependencies; every other file of the block refers to it by scoped names.
package pdad_pkg;

	// Fixed widths of the channel and register fields.
	localparam int unsigned CAPTURE_W = 16;
	localparam int unsigned RELOAD_W  = 16;
	localparam int unsigned ANGLE_W   = 17;
	localparam int unsigned TICKS_W   = 16;

	// Width of the full-turn constant and the constant itself.
	localparam int unsigned TURN_W = 9;
	localparam logic [TURN_W-1:0] FULL_TURN_DEG = 9'd360;

	// Reset value of the capture reload register.
	localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'hFFFF;

	// Event kinds carried by the op field.
	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;  // an event is transferred in this cycle
		logic setup;   // form the dividend and latch the validity check
		logic step;    // retire one quotient bit
		logic load;    // move the finished result into the output register
	} pdad_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // output register is empty or is being emptied
	} pdad_sts_t;

endpackage

// File: rtl/pdad_capture_if.sv
// Capture event channel of the PWM duty-cycle angle decoder.
// Carries valid, ready and the event fields; depends on pdad_pkg for widths.
interface pdad_capture_if;

	logic                               valid;
	logic                               ready;
	logic                               op;
	logic [pdad_pkg::CAPTURE_W-1:0]     period_cap;
	logic [pdad_pkg::CAPTURE_W-1:0]     high_cap;

	modport source (output valid, op, period_cap, high_cap, input ready);
	modport sink   (input valid, op, period_cap, high_cap, output ready);

endinterface

// File: rtl/pdad_result_if.sv
// Result channel of the PWM duty-cycle angle decoder.
// Carries valid, ready and the result fields; depends on pdad_pkg for widths.
interface pdad_result_if;

	logic                             valid;
	logic                             ready;
	logic                             angle_valid;
	logic [pdad_pkg::ANGLE_W-1:0]     angle;
	logic [pdad_pkg::TICKS_W-1:0]     period_len;
	logic [pdad_pkg::TICKS_W-1:0]     high_len;

	modport source (output valid, angle_valid, angle, period_len, high_len, input ready);
	modport sink   (input valid, angle_valid, angle, period_len, high_len, output ready);

endinterface

// File: rtl/pwm_duty_angle_decoder_unit.sv
// PWM duty-cycle angle decoder. Each capture or timeout event transferred on the
// capture channel yields exactly one result: the stored period and high time and
// the angle high*360/period with ANGLE_FRAC_BITS fractional bits. After an event
// is transferred, a setup step forms the dividend, the radix-2 divider retires one
// quotient bit per cycle, and the result is loaded into the output register; one
// event is processed at a time, and the next event is taken in the cycle after the
// previous result enters the output register. A result held back by the receiver
// stalls the next event. The reload register may be written only while no event
// is in flight.
module pwm_duty_angle_decoder_unit #(
	parameter int unsigned TIMER_BITS      = 16,
	parameter int unsigned ANGLE_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pdad_pkg::RELOAD_W-1:0]     cfg_wr_data,
	pdad_capture_if.sink                      capture,
	pdad_result_if.source                     result
);

	localparam int unsigned QUOT_W = pdad_pkg::TURN_W + ANGLE_FRAC_BITS;

	pdad_pkg::pdad_cmd_t cmd;
	pdad_pkg::pdad_sts_t sts;

	// Sequencer.
	pdad_ctrl #(
		.QUOT_W (QUOT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (capture.valid),
		.in_ready (capture.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// State, divider and output register.
	pdad_datapath #(
		.TIMER_BITS      (TIMER_BITS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.op          (capture.op),
		.period_cap  (capture.period_cap),
		.high_cap    (capture.high_cap),
		.res_ready   (result.ready),
		.res_valid   (result.valid),
		.angle_valid (result.angle_valid),
		.angle       (result.angle),
		.period_len  (result.period_len),
		.high_len    (result.high_len)
	);

endmodule

// File: rtl/pdad_ctrl.sv
// Controller of the PWM duty-cycle angle decoder: sequences accept, setup,
// the bit-serial division and delivery. Depends on pdad_pkg for the command and status structs.
module pdad_ctrl #(
	parameter int unsigned QUOT_W = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pdad_pkg::pdad_sts_t   sts,
	output pdad_pkg::pdad_cmd_t   cmd
);

	localparam int unsigned CNT_W = $clog2(QUOT_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   bit_cnt_q;

	// Commands follow directly from the state and the handshake inputs.
	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.accept = (state_q == ST_IDLE) && in_valid;
	assign cmd.setup  = (state_q == ST_SETUP);
	assign cmd.step   = (state_q == ST_DIVIDE);
	assign cmd.load   = (state_q == ST_DELIVER) && sts.out_free;

	// State register and quotient bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					bit_cnt_q <= CNT_W'(QUOT_W - 1);
					state_q   <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (bit_cnt_q == '0) begin
						state_q <= ST_DELIVER;
					end else begin
						bit_cnt_q <= bit_cnt_q - 1'b1;
					end
				end
				ST_DELIVER: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/pdad_datapath.sv
// Datapath of the PWM duty-cycle angle decoder: reload register, sync and
// measurement state, the radix-2 restoring divider and the output register.
// Depends on pdad_pkg; driven by commands from pdad_ctrl.
module pdad_datapath #(
	parameter int unsigned TIMER_BITS      = 16,
	parameter int unsigned ANGLE_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pdad_pkg::RELOAD_W-1:0]     cfg_wr_data,
	input  pdad_pkg::pdad_cmd_t               cmd,
	output pdad_pkg::pdad_sts_t               sts,
	input  logic                              op,
	input  logic [pdad_pkg::CAPTURE_W-1:0]    period_cap,
	input  logic [pdad_pkg::CAPTURE_W-1:0]    high_cap,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic                              angle_valid,
	output logic [pdad_pkg::ANGLE_W-1:0]      angle,
	output logic [pdad_pkg::TICKS_W-1:0]      period_len,
	output logic [pdad_pkg::TICKS_W-1:0]      high_len
);

	localparam int unsigned TB     = TIMER_BITS;
	localparam int unsigned QUOT_W = pdad_pkg::TURN_W + ANGLE_FRAC_BITS;
	localparam int unsigned PROD_W = TB + pdad_pkg::TURN_W;
	localparam int unsigned DVD_W  = PROD_W + ANGLE_FRAC_BITS;

	logic [pdad_pkg::RELOAD_W-1:0]  reload_q;
	logic                           synced_q;
	logic                           meas_valid_q;
	logic [TB-1:0]                  period_q;
	logic [TB-1:0]                  high_q;

	logic                           ok_q;
	logic [TB-1:0]                  rem_q;
	logic [QUOT_W-1:0]              quot_q;

	logic                           res_valid_q;
	logic                           angle_valid_q;
	logic [pdad_pkg::ANGLE_W-1:0]   angle_q;
	logic [pdad_pkg::TICKS_W-1:0]   period_len_q;
	logic [pdad_pkg::TICKS_W-1:0]   high_len_q;

	logic [TB-1:0]                  reload_m;
	logic [TB-1:0]                  pcap_m;
	logic [TB-1:0]                  hcap_m;
	logic [PROD_W-1:0]              product;
	logic [DVD_W-1:0]               dividend;
	logic [TB:0]                    trial;
	logic [TB-1:0]                  diff;
	logic                           fits;

	// Reload and captures taken modulo the timer width.
	assign reload_m = TB'(reload_q);
	assign pcap_m   = TB'(period_cap);
	assign hcap_m   = TB'(high_cap);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= pdad_pkg::RELOAD_RESET;
		end else if (cfg_wr_en) begin
			reload_q <= cfg_wr_data;
		end
	end

	// Sync and measurement state, updated when an event is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q     <= 1'b0;
			meas_valid_q <= 1'b0;
			period_q     <= '0;
			high_q       <= '0;
		end else if (cmd.accept) begin
			if (op == pdad_pkg::OP_TIMEOUT) begin
				synced_q     <= 1'b0;
				meas_valid_q <= 1'b0;
			end else if (synced_q) begin
				period_q     <= reload_m - pcap_m;
				high_q       <= reload_m - hcap_m;
				meas_valid_q <= 1'b1;
			end else begin
				synced_q <= 1'b1;
			end
		end
	end

	// Dividend high*360 scaled by the fractional bits.
	assign product  = PROD_W'(high_q) * PROD_W'(pdad_pkg::FULL_TURN_DEG);
	assign dividend = DVD_W'(product) << ANGLE_FRAC_BITS;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	// The difference is below the period whenever it is used, so TB bits hold it.
	assign trial = {rem_q, quot_q[QUOT_W-1]};
	assign diff  = trial[TB-1:0] - period_q;
	assign fits  = (trial >= {1'b0, period_q});

	// Divider registers. Since high <= period the quotient fits in QUOT_W bits,
	// so the upper dividend bits start out as a partial remainder below the period.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			ok_q   <= meas_valid_q && (period_q != '0) && (high_q <= period_q);
			rem_q  <= dividend[DVD_W-1:QUOT_W];
			quot_q <= dividend[QUOT_W-1:0];
		end else if (cmd.step) begin
			rem_q  <= fits ? diff : trial[TB-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			angle_valid_q <= ok_q;
			angle_q       <= ok_q ? pdad_pkg::ANGLE_W'(quot_q) : '0;
			period_len_q  <= pdad_pkg::TICKS_W'(period_q);
			high_len_q    <= pdad_pkg::TICKS_W'(high_q);
		end
	end

	assign sts.out_free = !res_valid_q || res_ready;
	assign res_valid    = res_valid_q;
	assign angle_valid  = angle_valid_q;
	assign angle        = angle_q;
	assign period_len   = period_len_q;
	assign high_len     = high_len_q;

endmodule

// File: rtl/pdad_checker.sv
// Port-level checker for the PWM duty-cycle angle decoder, with its bind to the top.
// Depends on pdad_pkg for widths.
module pdad_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cap_valid,
	input logic                             cap_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic                             angle_valid,
	input logic [pdad_pkg::ANGLE_W-1:0]     angle,
	input logic [pdad_pkg::TICKS_W-1:0]     period_len,
	input logic [pdad_pkg::TICKS_W-1:0]     high_len
);

	// A stalled result keeps its valid and its fields.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(angle_valid) && $stable(angle)
			&& $stable(period_len) && $stable(high_len))
		else $error("result changed while stalled");

	// An invalid measurement always reports a zero angle.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !angle_valid |-> angle == '0)
		else $error("nonzero angle without angle_valid");

	// Only one event is in flight: no transfer in the cycle after a transfer.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cap_valid && cap_ready |=> !cap_ready)
		else $error("capture channel ready right after a transfer");

	// A result cannot appear in the cycle after an event is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		cap_valid && cap_ready |=> !$rose(res_valid))
		else $error("result appeared too early");

endmodule

bind pwm_duty_angle_decoder_unit pdad_checker u_pdad_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cap_valid   (capture.valid),
	.cap_ready   (capture.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.angle_valid (result.angle_valid),
	.angle       (result.angle),
	.period_len  (result.period_len),
	.high_len    (result.high_len)
);

// File: verif/tb_top.sv
// Self-checking testbench for the PWM duty-cycle angle decoder.
// Depends on pdad_pkg, pdad_capture_if, pdad_result_if and pwm_duty_angle_decoder_unit.
// Events go in through a queued driver, and every result is checked against a local decoder model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TIMER_BITS   = 16;
	localparam int unsigned FRAC_BITS    = 8;
	localparam int unsigned LIMIT_CYCLES = 1000000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned PHASE_EVENTS = 275;
	localparam int unsigned PHASE_COUNT  = 6;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned REPORT_MAX   = 10;

	// One capture-channel event as the decoder sees it.
	typedef struct packed {
		logic                           op;
		logic [pdad_pkg::CAPTURE_W-1:0] period_cap;
		logic [pdad_pkg::CAPTURE_W-1:0] high_cap;
	} pwm_event_t;

	// One angle reading on the result channel.
	typedef struct packed {
		logic                         angle_valid;
		logic [pdad_pkg::ANGLE_W-1:0] angle;
		logic [pdad_pkg::TICKS_W-1:0] period_len;
		logic [pdad_pkg::TICKS_W-1:0] high_len;
	} angle_reading_t;

	bit clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [pdad_pkg::RELOAD_W-1:0] cfg_wr_data;

	pdad_capture_if cap_ch();
	pdad_result_if  res_ch();

	pwm_duty_angle_decoder_unit #(
		.TIMER_BITS     (TIMER_BITS),
		.ANGLE_FRAC_BITS(FRAC_BITS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.capture    (cap_ch),
		.result     (res_ch)
	);

	// Mirror of the decoder state and its reload register.
	logic [pdad_pkg::RELOAD_W-1:0] reload_mirror;
	logic [pdad_pkg::TICKS_W-1:0]  period_mirror;
	logic [pdad_pkg::TICKS_W-1:0]  high_mirror;
	bit                            synced_mirror;
	bit                            measured_mirror;

	pwm_event_t     event_q[$];
	angle_reading_t reading_q[$];
	angle_reading_t got_reading;
	angle_reading_t want_reading;
	angle_reading_t new_reading;

	bit          event_taken;
	bit          hold_req;
	bit          quiet;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned hold_left;
	int unsigned mismatches;
	int unsigned cycle_cnt;

	always #1 clk = ~clk;

	// Gap length: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(16, 80);
	endfunction

	// Advance the mirrored decoder by one event and form the reading it yields.
	task automatic decode_event(input pwm_event_t ev, output angle_reading_t rd);
		bit [63:0] dividend;
		bit [63:0] quotient;
		bit        ok;
		if (ev.op == pdad_pkg::OP_CAPTURE) begin
			if (synced_mirror) begin
				period_mirror   = reload_mirror - ev.period_cap;
				high_mirror     = reload_mirror - ev.high_cap;
				measured_mirror = 1'b1;
			end else begin
				synced_mirror = 1'b1;
			end
		end else begin
			synced_mirror   = 1'b0;
			measured_mirror = 1'b0;
		end
		ok = measured_mirror && period_mirror != 0 && high_mirror <= period_mirror;
		quotient = 64'd0;
		if (ok) begin
			dividend = 64'(high_mirror);
			dividend = dividend * 64'(pdad_pkg::FULL_TURN_DEG);
			dividend = dividend << FRAC_BITS;
			quotient = dividend / 64'(period_mirror);
		end
		rd.angle_valid = ok;
		rd.angle       = quotient[pdad_pkg::ANGLE_W-1:0];
		rd.period_len  = period_mirror;
		rd.high_len    = high_mirror;
	endtask

	// Random event: mostly a consistent period/high pair, some timeouts and some noise.
	function automatic pwm_event_t random_event();
		pwm_event_t  ev;
		int unsigned r;
		int unsigned p;
		int unsigned h;
		r = $urandom_range(0, 99);
		ev.op = pdad_pkg::OP_CAPTURE;
		ev.period_cap = 16'($urandom_range(0, 65535));
		ev.high_cap = 16'($urandom_range(0, 65535));
		if (r < 8) begin
			ev.op = pdad_pkg::OP_TIMEOUT;
		end else if (r >= 18) begin
			if ($urandom_range(0, 4) == 0)
				p = $urandom_range(1, 24);
			else
				p = $urandom_range(1, 65535);
			case ($urandom_range(0, 9))
				0: h = 0;
				1: h = p;
				2: h = p + 1;
				default: h = $urandom_range(0, p);
			endcase
			ev.period_cap = reload_mirror - p[15:0];
			ev.high_cap = reload_mirror - h[15:0];
		end
		return ev;
	endfunction

	task automatic queue_event(input logic op, input logic [pdad_pkg::CAPTURE_W-1:0] pcap,
			input logic [pdad_pkg::CAPTURE_W-1:0] hcap);
		event_q.push_back({op, pcap, hcap});
	endtask

	// Reload writes happen only while nothing is in flight.
	task automatic write_reload(input logic [pdad_pkg::RELOAD_W-1:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		reload_mirror = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic wait_idle();
		while (event_q.size() != 0 || cap_ch.valid || reading_q.size() != 0)
			@(negedge clk);
	endtask

	// Sender: offers queued events with random gaps between transfers.
	always @(negedge clk) begin
		if (!arst_n) begin
			cap_ch.valid <= 1'b0;
			event_taken = 1'b0;
			send_gap = 0;
		end else if (!cap_ch.valid || event_taken) begin
			event_taken = 1'b0;
			if (send_gap != 0) begin
				send_gap--;
				cap_ch.valid <= 1'b0;
			end else if (event_q.size() != 0) begin
				pwm_event_t ev;
				ev = event_q.pop_front();
				cap_ch.valid <= 1'b1;
				cap_ch.op <= ev.op;
				cap_ch.period_cap <= ev.period_cap;
				cap_ch.high_cap <= ev.high_cap;
				send_gap = quiet ? 0 : pick_gap();
			end else begin
				cap_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Monitor: check each result transfer, then predict from each event transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got_reading = {res_ch.angle_valid, res_ch.angle, res_ch.period_len,
					res_ch.high_len};
				if (reading_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result with none expected: valid=%0d angle=%0d period=%0d high=%0d",
							$realtime, got_reading.angle_valid, got_reading.angle,
							got_reading.period_len, got_reading.high_len);
				end else begin
					want_reading = reading_q.pop_front();
					if (got_reading.angle_valid !== want_reading.angle_valid ||
							got_reading.angle !== want_reading.angle ||
							got_reading.period_len !== want_reading.period_len ||
							got_reading.high_len !== want_reading.high_len) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%0t: mismatch: expected valid=%0d angle=%0d period=%0d high=%0d, got valid=%0d angle=%0d period=%0d high=%0d",
								$realtime, want_reading.angle_valid, want_reading.angle,
								want_reading.period_len, want_reading.high_len,
								got_reading.angle_valid, got_reading.angle,
								got_reading.period_len, got_reading.high_len);
					end
				end
			end
			if (cap_ch.valid && cap_ch.ready) begin
				decode_event({cap_ch.op, cap_ch.period_cap, cap_ch.high_cap},
					new_reading);
				reading_q.push_back(new_reading);
				event_taken = 1'b1;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus: reset, directed events, then random phases over several reload values.
	initial begin : stimulus
		int unsigned ph;
		int unsigned n;
		logic [pdad_pkg::RELOAD_W-1:0] next_reload;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cap_ch.valid = 1'b0;
		cap_ch.op = pdad_pkg::OP_CAPTURE;
		cap_ch.period_cap = '0;
		cap_ch.high_cap = '0;
		res_ch.ready = 1'b0;
		reload_mirror = pdad_pkg::RELOAD_RESET;
		period_mirror = '0;
		high_mirror = '0;
		synced_mirror = 1'b0;
		measured_mirror = 1'b0;
		hold_req = 1'b0;
		quiet = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Reset reload: sync-only first capture, full and zero spans, inconsistent pairs,
		// truncation, timeouts that keep the stores, and resync after a timeout.
		queue_event(pdad_pkg::OP_CAPTURE, 16'h0000, 16'h0000);
		queue_event(pdad_pkg::OP_CAPTURE, 16'h0000, 16'h0000);
		queue_event(pdad_pkg::OP_CAPTURE, 16'hFFFF, 16'hFFFF);
		queue_event(pdad_pkg::OP_CAPTURE, 16'h7FFF, 16'h0000);
		queue_event(pdad_pkg::OP_CAPTURE, 16'hFF9B, 16'hFFFF);
		queue_event(pdad_pkg::OP_CAPTURE, 16'hFFFC, 16'hFFFE);
		queue_event(pdad_pkg::OP_CAPTURE, 16'hFFF8, 16'hFFFC);
		queue_event(pdad_pkg::OP_CAPTURE, 16'hFFFE, 16'hFFFE);
		queue_event(pdad_pkg::OP_CAPTURE, 16'h0000, 16'hFFFE);
		queue_event(pdad_pkg::OP_TIMEOUT, 16'hFFFF, 16'hFFFF);
		queue_event(pdad_pkg::OP_TIMEOUT, 16'h0000, 16'h0000);
		queue_event(pdad_pkg::OP_CAPTURE, 16'h1234, 16'h5678);
		queue_event(pdad_pkg::OP_CAPTURE, 16'hAAAA, 16'hD555);
		queue_event(pdad_pkg::OP_CAPTURE, 16'hFFFF, 16'h0000);
		queue_event(pdad_pkg::OP_TIMEOUT, 16'h5555, 16'hAAAA);
		wait_idle();

		// Zero reload: captures above the reload wrap around.
		write_reload(16'h0000);
		queue_event(pdad_pkg::OP_CAPTURE, 16'h0000, 16'h0000);
		queue_event(pdad_pkg::OP_CAPTURE, 16'h0001, 16'h0002);
		queue_event(pdad_pkg::OP_CAPTURE, 16'h0000, 16'h0000);
		queue_event(pdad_pkg::OP_CAPTURE, 16'hFFFF, 16'hFFFF);
		queue_event(pdad_pkg::OP_CAPTURE, 16'h8000, 16'hC000);
		wait_idle();

		// Random phases; one runs without idling and one holds the receiver off.
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: next_reload = 16'hFFFF;
				1: next_reload = 16'h0000;
				2: next_reload = 16'h8000;
				3: next_reload = 16'h0001;
				default: next_reload = 16'($urandom_range(0, 65535));
			endcase
			write_reload(next_reload);
			quiet = (ph == 2);
			if (ph == 3)
				hold_req = 1'b1;
			for (n = 0; n < PHASE_EVENTS; n++)
				event_q.push_back(random_event());
			wait_idle();
		end
		quiet = 1'b0;

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
